// ----- design/pq_pkg.sv -----
// Shared types and constants for the palette quantizer.
`default_nettype none
package pq_pkg;

  localparam int PQ_ENTRIES = 255;
  localparam int PQ_IDX_W   = 8;
  localparam logic [7:0] PQ_TRANSPARENT = 8'd255;
  localparam logic [9:0] PQ_RECIP3 = 10'd683;   // 2^11 / 3, rounded up

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_QUANT = 2'd1,
    FUNC_ACCUM = 2'd2,
    FUNC_START = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_QUOT,
    ST_SEARCH,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                start;
    logic                valid;
    logic [PQ_IDX_W-1:0] idx;
  } dist_ctrl_t;

  typedef struct packed {
    logic                busy;
    logic [PQ_IDX_W-1:0] best;
  } dist_stat_t;

endpackage
`default_nettype wire

// ----- design/pq_if.sv -----
// Request and result channel interfaces.
`default_nettype none
interface pq_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       block_last;
  modport source (output valid, func, entry_index, red, green, blue, alpha, block_last,
                  input ready);
  modport sink   (input valid, func, entry_index, red, green, blue, alpha, block_last,
                  output ready);
endinterface

interface pq_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       masked_seen;
  modport source (output valid, palette_index, out_red, out_green, out_blue, out_alpha,
                  masked_seen, input ready);
  modport sink   (input valid, palette_index, out_red, out_green, out_blue, out_alpha,
                  masked_seen, output ready);
endinterface
`default_nettype wire

// ----- design/pq_cell.sv -----
// One palette cell of the rotating entry ring.
`default_nettype none
module pq_cell (
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic [23:0] load_data,
  input  wire logic        shift,
  input  wire logic [23:0] shift_in,
  output logic      [23:0] entry
);
  always_ff @(posedge clk) begin
    if (load) begin
      entry <= load_data;
    end else if (shift) begin
      entry <= shift_in;
    end
  end
endmodule
`default_nettype wire

// ----- design/pq_dist.sv -----
// Squared-distance unit with running minimum over the entries fed to it.
`default_nettype none
module pq_dist import pq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dist_ctrl_t  ctrl,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic [23:0] entry,
  output dist_stat_t       stat
);
  logic [7:0]          dr, dg, db;
  logic [15:0]         sq_r, sq_g, sq_b;
  logic                s1_valid;
  logic [PQ_IDX_W-1:0] s1_idx;
  logic [17:0]         sum_sq, best_dist;
  logic                have_best;
  logic [PQ_IDX_W-1:0] best;

  always_comb begin
    dr = (red   >= entry[23:16]) ? red   - entry[23:16] : entry[23:16] - red;
    dg = (green >= entry[15:8])  ? green - entry[15:8]  : entry[15:8]  - green;
    db = (blue  >= entry[7:0])   ? blue  - entry[7:0]   : entry[7:0]   - blue;
    sum_sq = {2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b};
  end

  // stage one: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= ctrl.valid;
    end
    sq_r   <= 16'(dr * dr);
    sq_g   <= 16'(dg * dg);
    sq_b   <= 16'(db * db);
    s1_idx <= ctrl.idx;
  end

  // stage two: sum and keep the strictly smaller
  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      have_best <= 1'b0;
    end else if (s1_valid && (!have_best || sum_sq < best_dist)) begin
      have_best <= 1'b1;
      best_dist <= sum_sq;
      best      <= s1_idx;
    end
  end

  assign stat.busy = s1_valid;
  assign stat.best = best;
endmodule
`default_nettype wire

// ----- design/palette_quantizer_with_mip_average.sv -----
// Top level: nearest-palette quantizer with 2x2 mip averaging.
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   func, entry_index, red, green, blue, alpha, block_last
//  res      out  valid/ready   palette_index, out_red/green/blue/alpha, masked_seen
//  cfg      in   cfg_we        cfg_wdata = swap_red_blue
//
// Load, start and non-final accumulate requests complete without leaving idle. A
// search rotates the ring of palette cells once past the distance unit, one entry
// a cycle, then lets the two-stage compare drain; averaging adds the divide states
// (ST_DIV, ST_QUOT) before the search. Transparent quantizes go straight to ST_DONE.
// Synchronous reset clears control, sums and the masked flag; palette cells
// are not reset. A stalled result holds in the output register while the
// block returns to idle and takes further requests.
`default_nettype none
module palette_quantizer_with_mip_average import pq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  pq_req_if.sink     req,
  pq_res_if.source   res
);
  state_t              state, state_next;
  logic                swap;
  logic [7:0]          in_r, in_b;
  logic                accept;

  logic [9:0]          sum_red, sum_green, sum_blue;
  logic [2:0]          opaque_count;
  logic                masked_flag;
  logic [9:0]          add_r, add_g, add_b;
  logic [2:0]          add_cnt;
  logic                add_take;

  logic [19:0]         prod_r, prod_g, prod_b;
  logic [7:0]          col_r, col_g, col_b, col_a;
  logic [7:0]          res_idx;
  logic                res_direct;

  logic [PQ_IDX_W-1:0] count;
  logic                shift;
  logic [23:0]         ring [PQ_ENTRIES];
  dist_ctrl_t          dctrl;
  dist_stat_t          dstat;
  logic                out_free;

  assign in_r     = swap ? req.blue : req.red;
  assign in_b     = swap ? req.red  : req.blue;
  assign accept   = req.valid && req.ready;
  assign out_free = !res.valid || res.ready;

  // surplus opaque texels past four are dropped
  assign add_take = (req.alpha != 8'd0) && (opaque_count < 3'd4);
  assign add_r    = add_take ? sum_red   + {2'b00, in_r}      : sum_red;
  assign add_g    = add_take ? sum_green + {2'b00, req.green} : sum_green;
  assign add_b    = add_take ? sum_blue  + {2'b00, in_b}      : sum_blue;
  assign add_cnt  = add_take ? opaque_count + 3'd1 : opaque_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap <= 1'b0;
    end else if (cfg_we) begin
      swap <= cfg_wdata;
    end
  end

  // ring of palette cells; cell 0 faces the distance unit
  for (genvar i = 0; i < PQ_ENTRIES; i++) begin : g_cell
    pq_cell u_cell (
      .clk       (clk),
      .load      (accept && func_t'(req.func) == FUNC_LOAD
                  && req.entry_index == PQ_IDX_W'(i)),
      .load_data ({req.red, req.green, req.blue}),
      .shift     (shift),
      .shift_in  (ring[(i + 1) % PQ_ENTRIES]),
      .entry     (ring[i])
    );
  end

  pq_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (dctrl),
    .red   (col_r),
    .green (col_g),
    .blue  (col_b),
    .entry (ring[0]),
    .stat  (dstat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (func_t'(req.func))
            FUNC_QUANT: state_next = (req.alpha == 8'd0) ? ST_DONE : ST_SEARCH;
            FUNC_ACCUM: begin
              if (req.block_last) begin
                state_next = (add_cnt == 3'd0) ? ST_DONE : ST_DIV;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIV:    state_next = ST_QUOT;
      ST_QUOT:   state_next = ST_SEARCH;
      ST_SEARCH: if (count == PQ_IDX_W'(PQ_ENTRIES - 1)) state_next = ST_DRAIN;
      ST_DRAIN:  if (!dstat.busy && !dctrl.valid) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready   = (state == ST_IDLE);
    shift       = (state == ST_SEARCH);
    dctrl.start = (state == ST_QUOT) || (accept && state_next == ST_SEARCH);
    dctrl.valid = (state == ST_SEARCH);
    dctrl.idx   = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sums, flag and search count
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_red      <= '0;
      sum_green    <= '0;
      sum_blue     <= '0;
      opaque_count <= '0;
      masked_flag  <= 1'b0;
      count        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          count <= '0;
          if (accept) begin
            case (func_t'(req.func))
              FUNC_START: begin
                masked_flag  <= 1'b0;
                sum_red      <= '0;
                sum_green    <= '0;
                sum_blue     <= '0;
                opaque_count <= '0;
              end
              FUNC_QUANT: begin
                if (req.alpha == 8'd0) begin
                  masked_flag <= 1'b1;
                end
              end
              FUNC_ACCUM: begin
                sum_red      <= add_r;
                sum_green    <= add_g;
                sum_blue     <= add_b;
                opaque_count <= add_cnt;
              end
              default: ;
            endcase
          end
        end
        ST_QUOT: begin
          sum_red      <= '0;
          sum_green    <= '0;
          sum_blue     <= '0;
          opaque_count <= '0;
        end
        ST_SEARCH: count <= count + PQ_IDX_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 20'(sum_red   * PQ_RECIP3);
    prod_g <= 20'(sum_green * PQ_RECIP3);
    prod_b <= 20'(sum_blue  * PQ_RECIP3);
    if (state == ST_IDLE && accept) begin
      res_direct <= 1'b1;
      res_idx    <= PQ_TRANSPARENT;
      case (func_t'(req.func))
        FUNC_QUANT: begin
          col_r <= in_r;
          col_g <= req.green;
          col_b <= in_b;
          col_a <= req.alpha;
          res_direct <= (req.alpha == 8'd0);
        end
        FUNC_ACCUM: begin
          // empty block: transparent black
          col_r <= '0;
          col_g <= '0;
          col_b <= '0;
          col_a <= '0;
          res_direct <= (add_cnt == 3'd0);
        end
        default: ;
      endcase
    end
    if (state == ST_QUOT) begin
      col_a <= 8'd255;
      case (opaque_count)
        3'd1: begin
          col_r <= sum_red[7:0];
          col_g <= sum_green[7:0];
          col_b <= sum_blue[7:0];
        end
        3'd2: begin
          col_r <= sum_red[8:1];
          col_g <= sum_green[8:1];
          col_b <= sum_blue[8:1];
        end
        3'd3: begin
          col_r <= prod_r[18:11];
          col_g <= prod_g[18:11];
          col_b <= prod_b[18:11];
        end
        default: begin
          col_r <= sum_red[9:2];
          col_g <= sum_green[9:2];
          col_b <= sum_blue[9:2];
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (state == ST_DONE && out_free) begin
      res.palette_index <= res_direct ? res_idx : dstat.best;
      res.out_red       <= col_r;
      res.out_green     <= col_g;
      res.out_blue      <= col_b;
      res.out_alpha     <= col_a;
      res.masked_seen   <= masked_flag;
    end
  end
endmodule
`default_nettype wire

// ----- design/pq_checker.sv -----
// Port-level checks for the palette quantizer, bound to the top level.
`default_nettype none
module pq_checker import pq_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic [1:0] req_func,
  input wire logic [7:0] req_alpha,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [7:0] res_index,
  input wire logic [7:0] res_alpha,
  input wire logic [7:0] res_red
);
  // transparent index goes with zero alpha and nothing else
  a_transparent: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_alpha == 8'd0) == (res_index == PQ_TRANSPARENT)))
    else $error("transparent index and alpha disagree");

  // an opaque quantize starts a search and holds off requests
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_func == FUNC_QUANT && req_alpha != 8'd0) |=> !req_ready)
    else $error("request taken during a search");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> ($stable(res_index) && $stable(res_red)))
    else $error("stalled result changed");
endmodule

bind palette_quantizer_with_mip_average pq_checker u_pq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_func  (req.func),
  .req_alpha (req.alpha),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_index (res.palette_index),
  .res_alpha (res.out_alpha),
  .res_red   (res.out_red)
);
`default_nettype wire
